@@ sv/kwm_pkg.sv @@
// Shared types, codes and key helper functions for the k-way merge unit.
package kwm_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [2:0] KK_INT8  = 3'd0;
   localparam logic [2:0] KK_INT16 = 3'd1;
   localparam logic [2:0] KK_INT32 = 3'd2;
   localparam logic [2:0] KK_INT64 = 3'd3;
   localparam logic [2:0] KK_F32   = 3'd4;
   localparam logic [2:0] KK_F64   = 3'd5;

   localparam logic CSR_NUM_RUNS = 1'b0;
   localparam logic CSR_KEY_KIND = 1'b1;

   typedef struct packed {
      logic        is_emit;
      logic        err;
      logic        stable;
      logic [2:0]  run;
      logic [63:0] key;
      logic [31:0] rid;
   } cmd_type;

   typedef struct packed {
      logic [31:0] row_id;
      logic [63:0] key;
      logic [1:0]  status;
      logic        all_stable;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] eff_runs(input logic [3:0] num, input logic [7:0] maxr);
      logic [7:0] n;
      n = {4'b0, num};
      if (num == 4'd0) return 8'd1;
      if (n > maxr) return maxr;
      return n;
   endfunction

   function automatic logic [63:0] norm_key(input logic [2:0] kind, input logic [63:0] raw);
      logic [63:0] r;
      case (kind)
         KK_INT8:  r = {{56{raw[7]}}, raw[7:0]};
         KK_INT16: r = {{48{raw[15]}}, raw[15:0]};
         KK_INT32: r = {{32{raw[31]}}, raw[31:0]};
         KK_F32:   r = {32'b0, raw[31:0]};
         default:  r = raw;
      endcase
      return r;
   endfunction

   // unsigned value whose order equals the key order
   function automatic logic [63:0] rank_key(input logic [2:0] kind, input logic [63:0] raw);
      logic [63:0] k;
      logic [63:0] r;
      k = norm_key(kind, raw);
      if (kind == KK_F32) begin
         if (k[30:0] == 31'b0) k = 64'b0;
         if (k[31]) r = {32'b0, ~k[31:0]};
         else r = {32'b0, 1'b1, k[30:0]};
      end else if (kind == KK_F64) begin
         if (k[62:0] == 63'b0) k = 64'b0;
         if (k[63]) r = ~k;
         else r = {1'b1, k[62:0]};
      end else begin
         r = {~k[63], k[62:0]};
      end
      return r;
   endfunction

endpackage

@@ sv/kwm_fifo.sv @@
// Two-entry word queue used between the front, the back and the result port.
module kwm_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

@@ sv/kwm_front.sv @@
// Front end: accepts request words, checks loads and tags each command.
module kwm_front #(
   parameter int CAPACITY = 1024,
   parameter int MAX_RUNS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic            req_operation,
   input  logic [2:0]      req_run,
   input  logic [63:0]     req_sort_key,
   input  logic [31:0]     req_row_id,
   input  logic            req_run_stable,
   input  logic [3:0]      num_runs,
   output logic            cmd_push,
   output kwm_pkg::cmd_type cmd_data,
   input  logic            cmd_full
);
   import kwm_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam logic [7:0] MAXR = 8'(MAX_RUNS);
   localparam logic [AW:0] CAP = (AW + 1)'(CAPACITY);

   logic          loading_ff, loading_in;
   logic          error_ff, error_in;
   logic          stable_ff, stable_in;
   logic [2:0]    cur_run_ff, cur_run_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          accept, bad_load;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;

   always_comb begin
      bad_load = !loading_ff || (req_run < cur_run_ff) ||
                 ({5'b0, req_run} >= eff_runs(num_runs, MAXR)) || (fill_ff >= CAP);
      loading_in = loading_ff;
      error_in   = error_ff;
      stable_in  = stable_ff;
      cur_run_in = cur_run_ff;
      fill_in    = fill_ff;
      cmd_push   = 1'b0;
      cmd_data.is_emit = req_operation;
      cmd_data.err     = error_ff;
      cmd_data.stable  = stable_ff;
      cmd_data.run     = req_run;
      cmd_data.key     = req_sort_key;
      cmd_data.rid     = req_row_id;
      if (accept) begin
         if (req_operation == OP_EMIT) begin
            cmd_push   = 1'b1;
            // an emit that only reports the error leaves loading open
            if (!error_ff) loading_in = 1'b0;
         end else if (bad_load) begin
            // drop the word
            error_in = 1'b1;
         end else begin
            cmd_push   = 1'b1;
            cur_run_in = req_run;
            fill_in    = fill_ff + 1'b1;
            stable_in  = stable_ff & req_run_stable;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loading_ff <= 1'b1;
         error_ff   <= 1'b0;
         stable_ff  <= 1'b1;
         cur_run_ff <= 3'd0;
         fill_ff    <= '0;
      end else begin
         loading_ff <= loading_in;
         error_ff   <= error_in;
         stable_ff  <= stable_in;
         cur_run_ff <= cur_run_in;
         fill_ff    <= fill_in;
      end
   end
endmodule

@@ sv/kwm_back.sv @@
// Back end: stores run elements, scans run heads and emits merged words.
module kwm_back #(
   parameter int CAPACITY = 1024,
   parameter int MAX_RUNS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  kwm_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   input  logic [3:0]       num_runs,
   input  logic [2:0]       key_kind,
   output logic             rsp_push,
   output kwm_pkg::rsp_type rsp_data,
   input  logic             rsp_full
);
   import kwm_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int RW = $clog2(MAX_RUNS);
   localparam int CW = $clog2(MAX_RUNS + 1);
   localparam logic [7:0] MAXR = 8'(MAX_RUNS);
   localparam logic [RW-1:0] LAST_IDX = RW'(MAX_RUNS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_EMIT = 4'b0100,
      S_FILL = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [63:0]  key_mem [CAPACITY];
   logic [31:0]  rid_mem [CAPACITY];
   logic [63:0]  rd_key_ff;
   logic [31:0]  rd_rid_ff;
   logic [AW:0]  rd_addr;
   logic         mem_we;

   logic [AW:0]  head_ff [MAX_RUNS];
   logic [AW:0]  end_ff [MAX_RUNS];
   logic [63:0]  hkey_ff [MAX_RUNS];
   logic [31:0]  hrid_ff [MAX_RUNS];
   logic [AW:0]  wr_ptr_ff;

   logic [RW-1:0] idx_ff, best_ff;
   logic          found_ff;
   logic [63:0]   best_rank_ff;
   logic [31:0]   best_rid_ff;
   logic [CW-1:0] live_ff;

   logic [RW-1:0] ld_run;
   logic          ld_first;
   logic          cand_live, tie_by_row, better;
   logic [63:0]   cand_rank;
   logic [AW:0]   next_head;

   assign ld_run     = RW'(cmd_data.run);
   assign ld_first   = head_ff[ld_run] == end_ff[ld_run];
   assign tie_by_row = eff_runs(num_runs, MAXR) >= 8'd3;
   assign cand_live  = head_ff[idx_ff] < end_ff[idx_ff];
   assign cand_rank  = rank_key(key_kind, hkey_ff[idx_ff]);
   assign better     = !found_ff || (cand_rank < best_rank_ff) ||
                       (tie_by_row && cand_rank == best_rank_ff &&
                        hrid_ff[idx_ff] < best_rid_ff);
   assign next_head  = head_ff[best_ff] + 1'b1;
   assign rd_addr    = next_head;
   assign mem_we     = (state_ff == S_IDLE) && !cmd_empty && !cmd_data.is_emit;

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data.row_id     = 32'b0;
      rsp_data.key        = 64'b0;
      rsp_data.status     = ST_VALID;
      rsp_data.all_stable = cmd_data.stable;
      rsp_data.last       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               if (!cmd_data.is_emit) begin
                  cmd_pop = 1'b1;
               end else if (!rsp_full) begin
                  if (cmd_data.err) begin
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_ERROR;
                     cmd_pop         = 1'b1;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == LAST_IDX) state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_push = 1'b1;
            cmd_pop  = 1'b1;
            if (!found_ff) begin
               rsp_data.status = ST_EMPTY;
               state_in = S_IDLE;
            end else begin
               rsp_data.row_id = hrid_ff[best_ff];
               rsp_data.key    = norm_key(key_kind, hkey_ff[best_ff]);
               rsp_data.last   = (live_ff == CW'(1)) && (next_head == end_ff[best_ff]);
               state_in = S_FILL;
            end
         end
         S_FILL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wr_ptr_ff <= '0;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         live_ff   <= '0;
         best_ff   <= '0;
         for (int i = 0; i < MAX_RUNS; i++) begin
            head_ff[i] <= '0;
            end_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (mem_we) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
            end_ff[ld_run] <= wr_ptr_ff + 1'b1;
            if (ld_first) head_ff[ld_run] <= wr_ptr_ff;
         end
         if (state_ff == S_IDLE) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
            live_ff  <= '0;
         end
         if (state_ff == S_SCAN) begin
            idx_ff <= idx_ff + 1'b1;
            if (cand_live) begin
               live_ff <= live_ff + 1'b1;
               if (better) begin
                  found_ff <= 1'b1;
                  best_ff  <= idx_ff;
               end
            end
         end
         // advance the chosen run
         if (state_ff == S_EMIT && found_ff) head_ff[best_ff] <= next_head;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && cand_live && better) begin
         best_rank_ff <= cand_rank;
         best_rid_ff  <= hrid_ff[idx_ff];
      end
      if (mem_we && ld_first) begin
         hkey_ff[ld_run] <= cmd_data.key;
         hrid_ff[ld_run] <= cmd_data.rid;
      end
      if (state_ff == S_FILL) begin
         hkey_ff[best_ff] <= rd_key_ff;
         hrid_ff[best_ff] <= rd_rid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_ptr_ff[AW-1:0]] <= cmd_data.key;
         rid_mem[wr_ptr_ff[AW-1:0]] <= cmd_data.rid;
      end
      rd_key_ff <= key_mem[rd_addr[AW-1:0]];
      rd_rid_ff <= rid_mem[rd_addr[AW-1:0]];
   end
endmodule

@@ sv/kway_merge_order_index_unit.sv @@
// Top level of the k-way merge order index unit.
//
//   channel | direction | handshake              | words
//   req_    | in        | push / full            | load element or emit request
//   rsp_    | out       | pop / empty            | one merged element or status
//   csr_    | in        | we, always taken       | num_runs, key_kind
//
// A load is written to the element store straight from idle. An emit goes
// through a start, a scan of every run head, delivery of the winner and a
// refill of its head from the element store. An emit that finds nothing left
// skips the refill. An emit after a load error is answered straight from idle.
// Reset is synchronous; the element store needs no clearing pass.
// Two-word queues between front, back and result port let each side stall alone.
module kway_merge_order_index_unit #(
   parameter int CAPACITY = 1024,
   parameter int MAX_RUNS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic [2:0]  req_run,
   input  logic [63:0] req_sort_key,
   input  logic [31:0] req_row_id,
   input  logic        req_run_stable,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_out_row_id,
   output logic [63:0] rsp_out_key,
   output logic [1:0]  rsp_status,
   output logic        rsp_all_stable,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);
   import kwm_pkg::*;

   logic [3:0] num_runs_ff;
   logic [2:0] key_kind_ff;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_out;
   logic [$bits(cmd_type)-1:0] cmd_out_vec;
   logic    back_push, back_full;
   rsp_type back_rsp, rsp_out;
   logic [$bits(rsp_type)-1:0] rsp_out_vec;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_runs_ff <= 4'd1;
         key_kind_ff <= KK_INT32;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_RUNS: num_runs_ff <= csr_wdata;
            CSR_KEY_KIND: key_kind_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   kwm_front #(.CAPACITY(CAPACITY), .MAX_RUNS(MAX_RUNS)) u_front (
      .clock, .reset, .req_push, .req_full, .req_operation, .req_run,
      .req_sort_key, .req_row_id, .req_run_stable,
      .num_runs(num_runs_ff), .cmd_push, .cmd_data(cmd_in), .cmd_full
   );

   kwm_fifo #(.WIDTH($bits(cmd_type))) u_cmd_q (
      .clock, .reset, .push(cmd_push), .push_data(cmd_in), .full(cmd_full),
      .pop(cmd_pop), .pop_data(cmd_out_vec), .empty(cmd_empty)
   );
   assign cmd_out = cmd_out_vec;

   kwm_back #(.CAPACITY(CAPACITY), .MAX_RUNS(MAX_RUNS)) u_back (
      .clock, .reset, .cmd_empty, .cmd_data(cmd_out), .cmd_pop,
      .num_runs(num_runs_ff), .key_kind(key_kind_ff),
      .rsp_push(back_push), .rsp_data(back_rsp), .rsp_full(back_full)
   );

   kwm_fifo #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock, .reset, .push(back_push), .push_data(back_rsp), .full(back_full),
      .pop(rsp_pop), .pop_data(rsp_out_vec), .empty(rsp_empty)
   );
   assign rsp_out = rsp_out_vec;

   assign rsp_out_row_id = rsp_out.row_id;
   assign rsp_out_key    = rsp_out.key;
   assign rsp_status     = rsp_out.status;
   assign rsp_all_stable = rsp_out.all_stable;
   assign rsp_last       = rsp_out.last;
endmodule
